/* design/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and codes of the timed command scheduler: input function codes,
// result status codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // Input function codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // A tick dispatches at most this many commands.
  localparam int unsigned MAX_OUT = 16;

  localparam int unsigned TARGET_SHIFT_RESET = 8;

  typedef enum logic [1:0] {
    ST_DISPATCH = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic    insert;        // Insert the request's command into the store.
    logic    load_stamp;    // Capture the tick timestamp.
    logic    pop;           // Move the head entry into the result register.
    logic    put_plain;     // Load a result without command payload.
    status_e plain_status;
    logic    last;          // Last flag for a popped result.
  } tcs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } tcs_sts_t;

endpackage

/* design/tcs_cmd_if.sv */
// ----------------------------------------------------------------------------
// tcs_cmd_if
// Request channel of the timed command scheduler: insert or tick.
// ----------------------------------------------------------------------------
interface tcs_cmd_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [15:0]        cmd_id;
  logic signed [31:0] cmd_data;
  logic [31:0]        stamp;

  modport source (output valid, output func, output cmd_id, output cmd_data,
                  output stamp, input ready);
  modport sink (input valid, input func, input cmd_id, input cmd_data,
                input stamp, output ready);
endinterface

/* design/tcs_res_if.sv */
// ----------------------------------------------------------------------------
// tcs_res_if
// Result channel of the timed command scheduler.
// ----------------------------------------------------------------------------
interface tcs_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        out_id;
  logic signed [31:0] out_data;
  logic [15:0]        target_bits;
  logic               target_invalid;
  logic               last;

  modport source (output valid, output status, output out_id, output out_data,
                  output target_bits, output target_invalid, output last,
                  input ready);
  modport sink (input valid, input status, input out_id, input out_data,
                input target_bits, input target_invalid, input last,
                output ready);
endinterface

/* design/tcs_store.sv */
// ----------------------------------------------------------------------------
// tcs_store
// Datapath: a time-sorted row of command entries, the tick timestamp, the
// target shift register and the result register.
// ----------------------------------------------------------------------------
module tcs_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcs_pkg::tcs_cmd_t  cmd_i,
  output tcs_pkg::tcs_sts_t  sts_o,
  input  logic [15:0]        in_id_i,
  input  logic signed [31:0] in_data_i,
  input  logic [31:0]        in_stamp_i,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output logic [1:0]         res_status_o,
  output logic [15:0]        res_id_o,
  output logic signed [31:0] res_data_o,
  output logic [15:0]        res_target_o,
  output logic               res_invalid_o,
  output logic               res_last_o
);
  import tcs_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0]        time_q [DEPTH];
  logic [15:0]        id_q   [DEPTH];
  logic signed [31:0] data_q [DEPTH];
  logic [CW-1:0]      count_q, count_d;
  logic [DEPTH-1:0]   le;
  logic [31:0]        stamp_q;
  logic [3:0]         shift_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [15:0]        out_id_q;
  logic signed [31:0] out_data_q;
  logic [15:0]        out_target_q;
  logic               out_invalid_q;
  logic               out_last_q;

  logic [15:0]        head_tb;
  logic               head_inv;

  // Entries stay sorted by time; on insert every entry at or before the new
  // time holds, the first later one takes the new command and the rest move up.
  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    localparam logic [CW-1:0] IDX = CW'(g);
    logic               prev_le;
    logic [31:0]        prv_time, nxt_time;
    logic [15:0]        prv_id, nxt_id;
    logic signed [31:0] prv_data, nxt_data;

    assign le[g] = (IDX < count_q) && (time_q[g] <= in_stamp_i);

    if (g == 0) begin : g_first
      assign prev_le  = 1'b1;
      assign prv_time = in_stamp_i;
      assign prv_id   = in_id_i;
      assign prv_data = in_data_i;
    end else begin : g_rest
      assign prev_le  = le[g-1];
      assign prv_time = time_q[g-1];
      assign prv_id   = id_q[g-1];
      assign prv_data = data_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_top
      assign nxt_time = time_q[g];
      assign nxt_id   = id_q[g];
      assign nxt_data = data_q[g];
    end else begin : g_below
      assign nxt_time = time_q[g+1];
      assign nxt_id   = id_q[g+1];
      assign nxt_data = data_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !le[g]) begin
        if (prev_le) begin
          time_q[g] <= in_stamp_i;
          id_q[g]   <= in_id_i;
          data_q[g] <= in_data_i;
        end else begin
          time_q[g] <= prv_time;
          id_q[g]   <= prv_id;
          data_q[g] <= prv_data;
        end
      end else if (cmd_i.pop) begin
        time_q[g] <= nxt_time;
        id_q[g]   <= nxt_id;
        data_q[g] <= nxt_data;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      shift_q <= 4'(TARGET_SHIFT_RESET);
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_stamp) begin
      stamp_q <= in_stamp_i;
    end
  end

  assign head_tb  = id_q[0] >> shift_q;
  assign head_inv = (head_tb == 16'd0) || ((head_tb & (head_tb - 16'd1)) != 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put_plain || cmd_i.pop) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_plain) begin
      out_status_q  <= cmd_i.plain_status;
      out_id_q      <= '0;
      out_data_q    <= '0;
      out_target_q  <= '0;
      out_invalid_q <= 1'b0;
      out_last_q    <= 1'b1;
    end else if (cmd_i.pop) begin
      out_status_q  <= ST_DISPATCH;
      out_id_q      <= id_q[0];
      out_data_q    <= data_q[0];
      out_target_q  <= head_tb;
      out_invalid_q <= head_inv;
      out_last_q    <= cmd_i.last;
    end
  end

  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.head_due = (count_q != '0) && (time_q[0] <= stamp_q);
  assign sts_o.next_due = (count_q > CW'(1)) && (time_q[1] <= stamp_q);
  assign sts_o.out_free = !out_valid_q || res_ready_i;

  assign res_valid_o   = out_valid_q;
  assign res_status_o  = out_status_q;
  assign res_id_o      = out_id_q;
  assign res_data_o    = out_data_q;
  assign res_target_o  = out_target_q;
  assign res_invalid_o = out_invalid_q;
  assign res_last_o    = out_last_q;

endmodule

/* design/tcs_ctrl.sv */
// ----------------------------------------------------------------------------
// tcs_ctrl
// Controller: takes requests, runs the dispatch sequence of a tick and counts
// the commands dispatched by it.
// ----------------------------------------------------------------------------
module tcs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_func_i,
  output logic              req_ready_o,
  input  tcs_pkg::tcs_sts_t sts_i,
  output tcs_pkg::tcs_cmd_t cmd_o
);
  import tcs_pkg::*;

  localparam int unsigned NW = $clog2(MAX_OUT);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_TICK = 1'b1;

  logic          state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = sts_i.out_free;
        if (req_valid_i && sts_i.out_free) begin
          if (req_func_i == FUNC_TICK) begin
            cmd_o.load_stamp = 1'b1;
            cnt_d            = '0;
            state_d          = S_TICK;
          end else begin
            cmd_o.put_plain    = 1'b1;
            cmd_o.insert       = !sts_i.full;
            cmd_o.plain_status = sts_i.full ? ST_FULL : ST_ACCEPTED;
          end
        end
      end
      S_TICK: begin
        if (sts_i.out_free) begin
          if (sts_i.head_due) begin
            // The burst ends at the dispatch limit or when the next entry is
            // not yet due.
            cmd_o.pop  = 1'b1;
            cmd_o.last = (cnt_q == NW'(MAX_OUT - 1)) || !sts_i.next_due;
            cnt_d      = cnt_q + NW'(1);
            if (cmd_o.last) begin
              state_d = S_IDLE;
            end
          end else begin
            cmd_o.put_plain    = 1'b1;
            cmd_o.plain_status = ST_NONE;
            state_d            = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/timed_command_scheduler_top.sv */
// ----------------------------------------------------------------------------
// timed_command_scheduler_top
// Keeps up to DEPTH commands sorted by execution time and dispatches those
// that are due when a tick arrives, earliest first, ties in insertion order.
//
//   channel   direction  handshake         payload
//   cmd_i     in         valid / ready     func, cmd_id, cmd_data, stamp
//   res_o     out        valid / ready     status, out_id, out_data,
//                                          target_bits, target_invalid, last
//   cfg       in         cfg_we_i          cfg_wdata_i (target shift)
//
// An insert gives one result. A tick first captures its timestamp and then
// dispatches its due commands (at most 16), or gives the single nothing-due
// result; the store head feeds one dispatch per cycle while the result
// register is free. A stalled result register holds the sequence in place.
// Reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module timed_command_scheduler_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcs_cmd_if.sink    cmd_i,
  tcs_res_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);
  import tcs_pkg::*;

  tcs_cmd_t ctl_cmd;
  tcs_sts_t dp_sts;

  tcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (cmd_i.valid),
    .req_func_i  (cmd_i.func),
    .req_ready_o (cmd_i.ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctl_cmd)
  );

  tcs_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctl_cmd),
    .sts_o         (dp_sts),
    .in_id_i       (cmd_i.cmd_id),
    .in_data_i     (cmd_i.cmd_data),
    .in_stamp_i    (cmd_i.stamp),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .res_ready_i   (res_o.ready),
    .res_valid_o   (res_o.valid),
    .res_status_o  (res_o.status),
    .res_id_o      (res_o.out_id),
    .res_data_o    (res_o.out_data),
    .res_target_o  (res_o.target_bits),
    .res_invalid_o (res_o.target_invalid),
    .res_last_o    (res_o.last)
  );

`ifndef SYNTHESIS
  // A command leaves the store only when it is due.
  a_pop_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.pop |-> dp_sts.head_due)
    else $error("pop issued for an entry that is not due");

  // A full store never takes another command.
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.insert |-> !dp_sts.full)
    else $error("insert issued while the store is full");

  // After a tick is taken no request is accepted until its burst is done.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready && cmd_i.func == FUNC_TICK) |=> !cmd_i.ready)
    else $error("request channel ready right after a tick");

  // Results without a dispatched command always close their request.
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != ST_DISPATCH) |-> res_o.last)
    else $error("non-dispatch result without last");
`endif

endmodule

/* tb/timed_command_scheduler_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_command_scheduler_top_tb
// Drives insert and tick requests into the scheduler with random idle cycles
// on both channels. A behavioral copy of the time-ordered store predicts the
// results the directed table does not give, and the result channel is checked
// field by field against both. The run opens with a table of directed requests
// and then runs random phases, each under a different target shift.
// ----------------------------------------------------------------------------
module timed_command_scheduler_top_tb;
  import tcs_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned N_DIRECTED   = 27;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS  = 40;
  localparam int unsigned QUIET_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT  = 20000;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_id;
    logic [31:0] out_data;
    logic [15:0] target_bits;
    logic        target_invalid;
    logic        last;
  } sched_result_t;

  // One row of the directed table. Where known is set, the request gives a
  // single plain result with known_status.
  typedef struct packed {
    logic        func;
    logic [15:0] id;
    logic [31:0] data;
    logic [31:0] stamp;
    logic        known;
    status_e     known_status;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  tcs_cmd_if cmd_if ();
  tcs_res_if res_if ();

  timed_command_scheduler_top #(
    .DEPTH(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Shadow of the command store.
  logic [31:0] slot_time [SLOTS];
  logic [15:0] slot_id   [SLOTS];
  logic [31:0] slot_data [SLOTS];
  int unsigned slot_count;
  logic [3:0]  shift_cfg;

  sched_result_t awaited_results [$];
  int unsigned   fail_count;
  logic          steady;

  // Travel alongside each request so the observer knows which rows are typed.
  logic          req_known;
  status_e       req_known_status;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_TICK,   16'h0000, 32'h00000000, 32'h00000000, 1'b1, ST_NONE},
    '{FUNC_INSERT, 16'h0100, 32'h7fffffff, 32'h00000000, 1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'hffff, 32'h80000000, 32'hffffffff, 1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0000, 32'h00000000, 32'h00000005, 1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0300, 32'hffffffff, 32'h00000005, 1'b1, ST_ACCEPTED},
    '{FUNC_TICK,   16'hffff, 32'hffffffff, 32'h00000004, 1'b0, ST_DISPATCH},
    '{FUNC_TICK,   16'h0000, 32'h00000000, 32'h00000005, 1'b0, ST_DISPATCH},
    '{FUNC_TICK,   16'h1234, 32'h5a5a5a5a, 32'hfffffffe, 1'b1, ST_NONE},
    '{FUNC_TICK,   16'h0000, 32'h00000000, 32'hffffffff, 1'b0, ST_DISPATCH},
    '{FUNC_INSERT, 16'h01ab, 32'h00000001, 32'd50,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0200, 32'h00000002, 32'd40,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0455, 32'h00000003, 32'd40,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0800, 32'h00000004, 32'd30,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h10ff, 32'hfffffffb, 32'd60,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h2001, 32'h00000006, 32'd10,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h4000, 32'h00000007, 32'd40,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h8080, 32'h80000008, 32'd70,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0300, 32'h00000009, 32'd20,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h00ff, 32'h0000000a, 32'd20,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'hc000, 32'h0000000b, 32'd80,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0101, 32'h0000000c, 32'd5,        1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0207, 32'h0000000d, 32'd90,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0480, 32'h0000000e, 32'd40,       1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'hffff, 32'h0000000f, 32'd100,      1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0001, 32'h00000010, 32'd1,        1'b1, ST_ACCEPTED},
    '{FUNC_INSERT, 16'h0001, 32'h00000011, 32'd0,        1'b1, ST_FULL},
    '{FUNC_TICK,   16'h0000, 32'h00000000, 32'hffffffff, 1'b0, ST_DISPATCH}
  };

  logic [3:0] shift_plan [N_PHASES] = '{
    4'd0, 4'd15, 4'd5, 4'd8, 4'd12, 4'd1, 4'd7, 4'd10
  };

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Works out the results of one accepted request and updates the shadow store.
  function automatic void schedule_request(input logic func, input logic [15:0] id,
                                           input logic [31:0] data,
                                           input logic [31:0] stamp,
                                           ref sched_result_t produced [$]);
    sched_result_t res;
    int unsigned   pos;
    int unsigned   n;
    logic [15:0]   tgt;
    res = '{ST_NONE, 16'h0, 32'h0, 16'h0, 1'b0, 1'b1};
    if (func == FUNC_INSERT) begin
      if (slot_count >= SLOTS) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < slot_count && slot_time[pos] <= stamp) pos++;
        for (int i = slot_count; i > pos; i--) begin
          slot_time[i] = slot_time[i-1];
          slot_id[i]   = slot_id[i-1];
          slot_data[i] = slot_data[i-1];
        end
        slot_time[pos] = stamp;
        slot_id[pos]   = id;
        slot_data[pos] = data;
        slot_count++;
        res.status = ST_ACCEPTED;
      end
      produced.push_back(res);
      return;
    end
    n = 0;
    while (n < MAX_OUT && slot_count > 0 && slot_time[0] <= stamp) begin
      tgt                = slot_id[0] >> shift_cfg;
      res.status         = ST_DISPATCH;
      res.out_id         = slot_id[0];
      res.out_data       = slot_data[0];
      res.target_bits    = tgt;
      res.target_invalid = ($countones(tgt) != 1);
      res.last           = 1'b0;
      produced.push_back(res);
      for (int i = 1; i < slot_count; i++) begin
        slot_time[i-1] = slot_time[i];
        slot_id[i-1]   = slot_id[i];
        slot_data[i-1] = slot_data[i];
      end
      slot_count--;
      n++;
    end
    if (n == 0) begin
      produced.push_back('{ST_NONE, 16'h0, 32'h0, 16'h0, 1'b0, 1'b1});
    end else begin
      produced[produced.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Observes both channels at the falling edge, where every signal is settled
  // for the handshake at the following rising edge.
  always @(negedge clk_i) begin : observe
    sched_result_t produced [$];
    sched_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) shift_cfg = cfg_wdata_i;
      if (cmd_if.valid && cmd_if.ready) begin
        produced.delete();
        schedule_request(cmd_if.func, cmd_if.cmd_id, cmd_if.cmd_data, cmd_if.stamp,
                         produced);
        if (req_known) begin
          awaited_results.push_back('{req_known_status, 16'h0, 32'h0, 16'h0, 1'b0, 1'b1});
        end else begin
          foreach (produced[i]) awaited_results.push_back(produced[i]);
        end
      end
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, res_if.status);
          check_field("out_id", want.out_id, res_if.out_id);
          check_field("out_data", want.out_data, res_if.out_data);
          check_field("target_bits", want.target_bits, res_if.target_bits);
          check_field("target_invalid", want.target_invalid, res_if.target_invalid);
          check_field("last", want.last, res_if.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_if.ready <= steady || ($urandom_range(0, 99) >= 15);
  end

  // Holds one request until it is accepted, then may leave a random gap.
  task automatic send_request(input logic func, input logic [15:0] id,
                              input logic [31:0] data, input logic [31:0] stamp,
                              input logic known, input status_e known_status);
    logic took;
    cmd_if.valid     <= 1'b1;
    cmd_if.func      <= func;
    cmd_if.cmd_id    <= id;
    cmd_if.cmd_data  <= data;
    cmd_if.stamp     <= stamp;
    req_known        <= known;
    req_known_status <= known_status;
    do begin
      @(negedge clk_i);
      took = cmd_if.ready;
      @(posedge clk_i);
    end while (!took);
    if (!steady && $urandom_range(0, 99) < 15) begin
      cmd_if.valid    <= 1'b0;
      cmd_if.func     <= 1'($urandom);
      cmd_if.cmd_id   <= 16'($urandom);
      cmd_if.cmd_data <= $urandom;
      cmd_if.stamp    <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Returns once every expected result has arrived, with a bound.
  task automatic wait_quiet();
    int unsigned guard;
    guard = 0;
    cmd_if.valid <= 1'b0;
    while (awaited_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] now_ts;
    logic [31:0] stamp;
    logic [15:0] id;
    logic [15:0] low_mask;
    logic [3:0]  cur_shift;
    int unsigned roll;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 4'd0;
    cmd_if.valid     = 1'b0;
    cmd_if.func      = FUNC_INSERT;
    cmd_if.cmd_id    = 16'h0;
    cmd_if.cmd_data  = 32'sh0;
    cmd_if.stamp     = 32'h0;
    res_if.ready     = 1'b0;
    req_known        = 1'b0;
    req_known_status = ST_DISPATCH;
    steady           = 1'b0;
    fail_count       = 0;
    slot_count       = 0;
    shift_cfg        = 4'(TARGET_SHIFT_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_request(directed_rows[r].func, directed_rows[r].id, directed_rows[r].data,
                   directed_rows[r].stamp, directed_rows[r].known,
                   directed_rows[r].known_status);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_quiet();
      cur_shift   = shift_plan[phase];
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= cur_shift;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      steady      = (phase == 3);
      now_ts      = (phase == 5) ? 32'hffffff00 : $urandom_range(0, 1000);
      low_mask    = (16'h1 << cur_shift) - 16'h1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          roll = $urandom_range(0, 99);
          if (roll < 80) stamp = now_ts + $urandom_range(0, 24);
          else if (roll < 90) stamp = $urandom;
          else if (roll < 95) stamp = 32'h0;
          else stamp = 32'hffffffff;
          // Mostly ids that name exactly one target, some arbitrary ones.
          if ($urandom_range(0, 99) < 60) begin
            id = (16'h1 << (cur_shift + $urandom_range(0, 15 - cur_shift)))
                 | (16'($urandom) & low_mask);
          end else begin
            id = 16'($urandom);
          end
          send_request(FUNC_INSERT, id, $urandom, stamp, 1'b0, ST_DISPATCH);
        end else begin
          now_ts = now_ts + $urandom_range(0, 12);
          stamp  = ($urandom_range(0, 99) < 5) ? 32'hffffffff : now_ts;
          send_request(FUNC_TICK, 16'($urandom), $urandom, stamp, 1'b0, ST_DISPATCH);
        end
      end
    end

    steady = 1'b0;
    wait_quiet();
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
